>>> rtl/core/rfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_pkg
// Types, codes and constants shared by the RFC 3339 timestamp parser.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int unsigned FracDigitsDef = 15;
  localparam int unsigned FracDigitsMax = 15;
  localparam int unsigned SecW          = 39;
  localparam int unsigned FracW         = 50;
  localparam int unsigned FcntW         = 5;
  localparam int unsigned FldW          = 7;
  localparam int unsigned PosW          = 5;
  localparam int unsigned AccW          = 52;
  localparam int unsigned CoefW         = 19;

  localparam logic [PosW-1:0] PrefixLast = PosW'(19 - 1);

  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChTLow  = 8'h74;
  localparam logic [7:0] ChZ     = 8'h5A;
  localparam logic [7:0] ChZLow  = 8'h7A;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic signed [CoefW-1:0] CoefEraRecip = 19'sd5243;  // 2^21 / 400
  localparam logic signed [CoefW-1:0] CoefCentRecip = 19'sd41;   // 2^12 / 100
  localparam logic signed [CoefW-1:0] CoefNegEra   = -19'sd400;
  localparam logic signed [CoefW-1:0] CoefCent     = 19'sd100;
  localparam logic signed [CoefW-1:0] CoefYear     = 19'sd365;
  localparam logic signed [CoefW-1:0] CoefEraDays  = 19'sd146097;
  localparam logic signed [CoefW-1:0] CoefHours    = 19'sd24;
  localparam logic signed [CoefW-1:0] CoefSixty    = 19'sd60;
  localparam logic signed [CoefW-1:0] CoefTen      = 19'sd10;
  localparam logic signed [AccW-1:0]  DaysToEpoch  = 52'sd719468;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_FORMAT    = 4'd1,
    ST_SEPARATOR = 4'd2,
    ST_MONTH     = 4'd3,
    ST_DAY       = 4'd4,
    ST_HOUR      = 4'd5,
    ST_MINUTE    = 4'd6,
    ST_SECOND    = 4'd7,
    ST_NOFRAC    = 4'd8,
    ST_OFFFMT    = 4'd9,
    ST_OFFHOUR   = 4'd10,
    ST_OFFMIN    = 4'd11,
    ST_ZONE      = 4'd12,
    ST_EXTRA     = 4'd13,
    ST_SHORT     = 4'd14
  } status_e;

  typedef enum logic [3:0] {
    PH_PREFIX, PH_ZONE, PH_FRAC0, PH_FRAC, PH_OH1, PH_OH2,
    PH_OCOL, PH_OM1, PH_OM2, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {CTL_IDLE, CTL_CONV, CTL_OUT} ctl_e;

  typedef enum logic [3:0] {
    CV_IDLE, CV_YEAR, CV_ERA, CV_YOE, CV_DOE1, CV_DOE2, CV_DAY, CV_HOUR,
    CV_MIN, CV_SEC, CV_OFFM, CV_OFFS, CV_FRAC, CV_FIN
  } cv_e;

  typedef struct packed {
    logic [FldW-1:0]  yhi;
    logic [FldW-1:0]  ylo;
    logic [FldW-1:0]  month;
    logic [FldW-1:0]  day;
    logic [FldW-1:0]  hour;
    logic [FldW-1:0]  minute;
    logic [FldW-1:0]  second;
    logic [FracW-1:0] frac;
    logic [FcntW-1:0] fcnt;
    logic             off_neg;
    logic [FldW-1:0]  off_hour;
    logic [FldW-1:0]  off_min;
  } conv_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [SecW-1:0] secs;
    logic [FracW-1:0]       fs;
  } conv_rsp_t;

  function automatic logic [FldW-1:0] max_day(input logic [FldW-1:0] m);
    logic [FldW-1:0] r;
    unique case (m)
      7'd2:                      r = 7'd29;
      7'd4, 7'd6, 7'd9, 7'd11:   r = 7'd30;
      7'd1, 7'd3, 7'd5, 7'd7,
      7'd8, 7'd10, 7'd12:        r = 7'd31;
      default:                   r = 7'd0;
    endcase
    return r;
  endfunction

  // (153 * shifted_month + 2) / 5, March-based
  function automatic logic [8:0] doy_base(input logic [FldW-1:0] m);
    logic [8:0] r;
    unique case (m)
      7'd3:    r = 9'd0;
      7'd4:    r = 9'd31;
      7'd5:    r = 9'd61;
      7'd6:    r = 9'd92;
      7'd7:    r = 9'd122;
      7'd8:    r = 9'd153;
      7'd9:    r = 9'd184;
      7'd10:   r = 9'd214;
      7'd11:   r = 9'd245;
      7'd12:   r = 9'd275;
      7'd1:    r = 9'd306;
      7'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rfc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_in_if
// Byte stream channel: one timestamp character per transaction.
// ----------------------------------------------------------------------------
interface rfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rfc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_out_if
// Result channel: status, epoch seconds and femtoseconds per transaction.
// ----------------------------------------------------------------------------
interface rfc_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic signed [38:0] epoch_seconds;
  logic [49:0]        femtoseconds;

  modport source (output valid, output status, output epoch_seconds,
                  output femtoseconds, input ready);
  modport sink   (input valid, input status, input epoch_seconds,
                  input femtoseconds, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rfc_conv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_conv
// Civil date/time to epoch seconds and fraction scaling on one shared
// multiply-add unit, stepped by a small sequencer.
// ----------------------------------------------------------------------------
module rfc_conv import rfc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire conv_req_t req_i,
  output conv_rsp_t      rsp_o
);

  cv_e step_q, step_d;
  conv_req_t req_q;
  logic signed [AccW-1:0] acc_q, era_q, yoe_q, t_q, off_q;
  logic [FracW-1:0] frac_q;
  logic [FcntW-1:0] fcnt_q;

  logic signed [AccW-1:0]        op_a, op_c, res;
  logic signed [CoefW-1:0]       op_b;
  logic signed [AccW+CoefW-1:0]  prod;
  logic [8:0] doy;

  assign doy  = 9'(doy_base(req_q.month) + 9'(req_q.day) - 9'd1);
  assign prod = op_a * op_b;
  assign res  = prod[AccW-1:0] + op_c;

  always_comb begin
    step_d = step_q;
    unique case (step_q)
      CV_IDLE: if (start_i) step_d = CV_YEAR;
      CV_YEAR: step_d = CV_ERA;
      CV_ERA:  step_d = CV_YOE;
      CV_YOE:  step_d = CV_DOE1;
      CV_DOE1: step_d = CV_DOE2;
      CV_DOE2: step_d = CV_DAY;
      CV_DAY:  step_d = CV_HOUR;
      CV_HOUR: step_d = CV_MIN;
      CV_MIN:  step_d = CV_SEC;
      CV_SEC:  step_d = CV_OFFM;
      CV_OFFM: step_d = CV_OFFS;
      CV_OFFS: step_d = CV_FRAC;
      CV_FRAC: if (fcnt_q >= FcntW'(FracDigitsMax)) step_d = CV_FIN;
      CV_FIN:  step_d = CV_IDLE;
      default: step_d = CV_IDLE;
    endcase
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    op_c = '0;
    unique case (step_q)
      CV_YEAR: begin
        op_a = AccW'(req_q.yhi);
        op_b = CoefCent;
        op_c = AccW'(req_q.ylo) - ((req_q.month <= 7'd2) ? 52'sd1 : 52'sd0);
      end
      CV_ERA: begin
        op_a = t_q;
        op_b = CoefEraRecip;
      end
      CV_YOE: begin
        op_a = era_q;
        op_b = CoefNegEra;
        op_c = t_q;
      end
      CV_DOE1: begin
        op_a = yoe_q;
        op_b = CoefYear;
        op_c = AccW'(doy) + (yoe_q >>> 2);
      end
      CV_DOE2: begin
        op_a = yoe_q;
        op_b = CoefCentRecip;
      end
      CV_DAY: begin
        op_a = era_q;
        op_b = CoefEraDays;
        op_c = t_q - DaysToEpoch;
      end
      CV_HOUR: begin
        op_a = acc_q;
        op_b = CoefHours;
        op_c = AccW'(req_q.hour);
      end
      CV_MIN: begin
        op_a = acc_q;
        op_b = CoefSixty;
        op_c = AccW'(req_q.minute);
      end
      CV_SEC: begin
        op_a = acc_q;
        op_b = CoefSixty;
        op_c = AccW'(req_q.second);
      end
      CV_OFFM: begin
        op_a = AccW'(req_q.off_hour);
        op_b = CoefSixty;
        op_c = AccW'(req_q.off_min);
      end
      CV_OFFS: begin
        op_a = off_q;
        op_b = CoefSixty;
      end
      CV_FRAC: begin
        op_a = AccW'(frac_q);
        op_b = CoefTen;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_o.done = (step_q == CV_FIN);
    rsp_o.secs = req_q.off_neg ? SecW'(acc_q + off_q) : SecW'(acc_q - off_q);
    rsp_o.fs   = frac_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= CV_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (step_q)
      CV_IDLE: if (start_i) begin
        req_q  <= req_i;
        frac_q <= req_i.frac;
        fcnt_q <= req_i.fcnt;
      end
      CV_YEAR: t_q   <= res;
      CV_ERA:  era_q <= t_q[AccW-1] ? -52'sd1 : (res >>> 21);
      CV_YOE:  yoe_q <= res;
      CV_DOE1: t_q   <= res;
      CV_DOE2: t_q   <= t_q - (res >>> 12);
      CV_DAY, CV_HOUR, CV_MIN, CV_SEC: acc_q <= res;
      CV_OFFM, CV_OFFS: off_q <= res;
      CV_FRAC: if (fcnt_q < FcntW'(FracDigitsMax)) begin
        frac_q <= FracW'(res);
        fcnt_q <= fcnt_q + 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/rfc3339_timestamp_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Results: an error result is shown the cycle after the last byte; a valid
//   timestamp is converted on the shared multiply-add unit, which scales the
//   fraction up from the k kept digits to 15 before the result is shown.
// Throughput: one byte per cycle; input stalls from the last byte until the
//   result transaction completes.
// Reset: parse state cleared, acc_off_q set to 1, no result pending.
// ----------------------------------------------------------------------------
// rfc3339_timestamp_parser_unit
// Byte-serial RFC 3339 timestamp checker and epoch converter.
// ----------------------------------------------------------------------------
module rfc3339_timestamp_parser_unit import rfc_pkg::*; #(
  parameter int unsigned FRACTION_DIGITS = FracDigitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rfc_in_if.sink    in_i,
  rfc_out_if.source out_o,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i
);

  localparam int unsigned FracCap =
      (FRACTION_DIGITS < FracDigitsMax) ? FRACTION_DIGITS : FracDigitsMax;

  ctl_e ctl_q, ctl_d;
  logic acc_off_q;

  phase_e phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [FldW-1:0] yhi_q, yhi_d, ylo_q, ylo_d, mon_q, mon_d, day_q, day_d;
  logic [FldW-1:0] hr_q, hr_d, min_q, min_d, sec_q, sec_d;
  logic [FldW-1:0] oh_q, oh_d, om_q, om_d;
  logic sep_q, sep_d, neg_q, neg_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic [FcntW-1:0] fcnt_q, fcnt_d;
  status_e err_q, err_d, fin_status;

  status_e out_status_q;
  logic signed [SecW-1:0] out_secs_q;
  logic [FracW-1:0] out_fs_q;

  logic in_fire, out_fire, start;
  logic [7:0] c;
  logic [3:0] dg;
  logic is_dig, leap;
  conv_req_t req;
  conv_rsp_t rsp;

  assign c       = in_i.text_byte;
  assign dg      = 4'(c - ChZero);
  assign is_dig  = (c >= ChZero) && (c <= ChNine);
  assign leap    = (ylo_q[1:0] == 2'd0) && ((ylo_q != '0) || (yhi_q[1:0] == 2'd0));
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  function automatic logic [FldW-1:0] acc10(input logic [FldW-1:0] v,
                                            input logic [3:0] d);
    return FldW'({v, 3'b000} + {v, 1'b0} + FldW'(d));
  endfunction

  // byte parser
  always_comb begin
    phase_d = phase_q; pos_d = pos_q;
    yhi_d = yhi_q; ylo_d = ylo_q; mon_d = mon_q; day_d = day_q;
    hr_d = hr_q; min_d = min_q; sec_d = sec_q; sep_d = sep_q;
    oh_d = oh_q; om_d = om_q; neg_d = neg_q;
    frac_d = frac_q; fcnt_d = fcnt_q; err_d = err_q;
    if (err_q == ST_OK) begin
      unique case (phase_q)
        PH_PREFIX: begin
          priority if (pos_q == 5'd4 || pos_q == 5'd7) begin
            if (c != ChDash) err_d = ST_FORMAT;
          end else if (pos_q == 5'd13 || pos_q == 5'd16) begin
            if (c != ChColon) err_d = ST_FORMAT;
          end else if (pos_q == 5'd10) begin
            sep_d = (c == ChT) || (c == ChTLow);
          end else if (!is_dig) begin
            err_d = ST_FORMAT;
          end else if (pos_q < 5'd2) begin
            yhi_d = acc10(yhi_q, dg);
          end else if (pos_q < 5'd4) begin
            ylo_d = acc10(ylo_q, dg);
          end else if (pos_q < 5'd7) begin
            mon_d = acc10(mon_q, dg);
          end else if (pos_q < 5'd10) begin
            day_d = acc10(day_q, dg);
          end else if (pos_q < 5'd13) begin
            hr_d = acc10(hr_q, dg);
          end else if (pos_q < 5'd16) begin
            min_d = acc10(min_q, dg);
          end else begin
            sec_d = acc10(sec_q, dg);
          end
          pos_d = pos_q + 1'b1;
          if (err_d == ST_OK && pos_q == PrefixLast) begin
            phase_d = PH_ZONE;
            priority if (!sep_q) err_d = ST_SEPARATOR;
            else if (mon_q < 7'd1 || mon_q > 7'd12) err_d = ST_MONTH;
            else if (day_q < 7'd1 || day_q > max_day(mon_q)) err_d = ST_DAY;
            else if (mon_q == 7'd2 && day_q > 7'd28 && !leap) err_d = ST_DAY;
            else if (hr_q > 7'd23) err_d = ST_HOUR;
            else if (min_q > 7'd59) err_d = ST_MINUTE;
            else if (sec_d > 7'd60) err_d = ST_SECOND;
            else err_d = ST_OK;
          end
        end
        PH_ZONE, PH_FRAC: begin
          priority if (phase_q == PH_ZONE && c == ChDot) begin
            phase_d = PH_FRAC0;
          end else if (phase_q == PH_FRAC && is_dig) begin
            if (fcnt_q < FcntW'(FracCap)) begin
              frac_d = FracW'({frac_q, 3'b000} + {frac_q, 1'b0} + FracW'(dg));
              fcnt_d = fcnt_q + 1'b1;
            end
          end else if (!acc_off_q) begin
            if (c == ChZ) phase_d = PH_DONE;
            else err_d = ST_ZONE;
          end else if (c == ChPlus || c == ChDash) begin
            neg_d = (c == ChDash);
            phase_d = PH_OH1;
          end else if (c == ChZ || c == ChZLow) begin
            phase_d = PH_DONE;
          end else begin
            err_d = ST_ZONE;
          end
        end
        PH_FRAC0: begin
          if (is_dig) begin
            if (fcnt_q < FcntW'(FracCap)) begin
              frac_d = FracW'({frac_q, 3'b000} + {frac_q, 1'b0} + FracW'(dg));
              fcnt_d = fcnt_q + 1'b1;
            end
            phase_d = PH_FRAC;
          end else begin
            err_d = ST_NOFRAC;
          end
        end
        PH_OH1, PH_OH2: begin
          if (!is_dig) begin
            err_d = ST_OFFFMT;
          end else begin
            oh_d = acc10(oh_q, dg);
            phase_d = (phase_q == PH_OH1) ? PH_OH2 : PH_OCOL;
          end
        end
        PH_OCOL: begin
          if (c == ChColon) phase_d = PH_OM1;
          else err_d = ST_OFFFMT;
        end
        PH_OM1, PH_OM2: begin
          if (!is_dig) begin
            err_d = ST_OFFFMT;
          end else begin
            om_d = acc10(om_q, dg);
            priority if (phase_q == PH_OM1) phase_d = PH_OM2;
            else if (oh_q > 7'd23) err_d = ST_OFFHOUR;
            else if (om_d > 7'd59) err_d = ST_OFFMIN;
            else phase_d = PH_DONE;
          end
        end
        PH_DONE: err_d = ST_EXTRA;
        default: err_d = ST_EXTRA;
      endcase
    end
  end

  always_comb begin
    if (err_d != ST_OK) begin
      fin_status = err_d;
    end else begin
      unique case (phase_d)
        PH_PREFIX: fin_status = ST_FORMAT;
        PH_ZONE:   fin_status = ST_SHORT;
        PH_FRAC0:  fin_status = ST_NOFRAC;
        PH_FRAC:   fin_status = ST_ZONE;
        PH_DONE:   fin_status = ST_OK;
        default:   fin_status = ST_OFFFMT;
      endcase
    end
  end

  always_comb begin
    req.yhi = yhi_d;  req.ylo = ylo_d;  req.month = mon_d;  req.day = day_d;
    req.hour = hr_d;  req.minute = min_d;  req.second = sec_d;
    req.frac = frac_d;  req.fcnt = fcnt_d;
    req.off_neg = neg_d;  req.off_hour = oh_d;  req.off_min = om_d;
  end

  rfc_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // control: next state
  always_comb begin
    ctl_d = ctl_q;
    unique case (ctl_q)
      CTL_IDLE: if (in_fire && in_i.is_last) begin
        ctl_d = (fin_status == ST_OK) ? CTL_CONV : CTL_OUT;
      end
      CTL_CONV: if (rsp.done) ctl_d = CTL_OUT;
      CTL_OUT:  if (out_fire) ctl_d = CTL_IDLE;
      default:  ctl_d = CTL_IDLE;
    endcase
  end

  // control: outputs
  always_comb begin
    in_i.ready          = (ctl_q == CTL_IDLE);
    out_o.valid         = (ctl_q == CTL_OUT);
    start               = in_fire && in_i.is_last && (fin_status == ST_OK);
    out_o.status        = out_status_q;
    out_o.epoch_seconds = out_secs_q;
    out_o.femtoseconds  = out_fs_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= CTL_IDLE;
      acc_off_q <= 1'b1;
      phase_q <= PH_PREFIX; pos_q <= '0;
      yhi_q <= '0; ylo_q <= '0; mon_q <= '0; day_q <= '0;
      hr_q <= '0; min_q <= '0; sec_q <= '0; sep_q <= 1'b0;
      oh_q <= '0; om_q <= '0; neg_q <= 1'b0;
      frac_q <= '0; fcnt_q <= '0; err_q <= ST_OK;
    end else begin
      ctl_q <= ctl_d;
      if (cfg_we_i) acc_off_q <= cfg_wdata_i;
      if (in_fire) begin
        if (in_i.is_last) begin
          phase_q <= PH_PREFIX; pos_q <= '0;
          yhi_q <= '0; ylo_q <= '0; mon_q <= '0; day_q <= '0;
          hr_q <= '0; min_q <= '0; sec_q <= '0; sep_q <= 1'b0;
          oh_q <= '0; om_q <= '0; neg_q <= 1'b0;
          frac_q <= '0; fcnt_q <= '0; err_q <= ST_OK;
        end else begin
          phase_q <= phase_d; pos_q <= pos_d;
          yhi_q <= yhi_d; ylo_q <= ylo_d; mon_q <= mon_d; day_q <= day_d;
          hr_q <= hr_d; min_q <= min_d; sec_q <= sec_d; sep_q <= sep_d;
          oh_q <= oh_d; om_q <= om_d; neg_q <= neg_d;
          frac_q <= frac_d; fcnt_q <= fcnt_d; err_q <= err_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.is_last) begin
      out_status_q <= fin_status;
      out_secs_q   <= '0;
      out_fs_q     <= '0;
    end else if (ctl_q == CTL_CONV && rsp.done) begin
      out_secs_q   <= rsp.secs;
      out_fs_q     <= rsp.fs;
    end
  end

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timestamp strings byte by byte into the RFC 3339 parser and checks
// every result against a local parser/epoch model, with random stalls on
// both channels and changes of the offset-mode register between strings.
// ----------------------------------------------------------------------------
module testbench;
  import rfc_pkg::*;

  localparam int WatchLimit = 5000;

  typedef struct {
    logic [3:0]         status;
    logic signed [38:0] secs;
    logic [49:0]        fs;
  } stamp_t;

  class stamp_scoreboard;
    stamp_t    pending[$];
    int        errors, results, ok_results;
    bit        acc_off;
    int        pos, yr, mo, dy, hr, mi, se, fcnt, oh, om;
    phase_e    ph;
    bit        sep, oneg;
    longint    frac;
    logic [3:0] ferr;

    function new();
      acc_off = 1;
      clear();
    endfunction

    function void clear();
      pos = 0; ph = PH_PREFIX; yr = 0; mo = 0; dy = 0; hr = 0; mi = 0; se = 0;
      sep = 0; frac = 0; fcnt = 0; oneg = 0; oh = 0; om = 0; ferr = ST_OK;
    endfunction

    function void fail(logic [3:0] c);
      if (ferr == ST_OK) ferr = c;
    endfunction

    function int days_in(int m, int y);
      bit leap;
      leap = (y % 4 == 0) && (y % 100 != 0 || y % 400 == 0);
      case (m)
        2: return leap ? 29 : 28;
        4, 6, 9, 11: return 30;
        default: return 31;
      endcase
    endfunction

    function logic [3:0] prefix_status();
      if (!sep) return ST_SEPARATOR;
      if (mo < 1 || mo > 12) return ST_MONTH;
      if (dy < 1 || dy > days_in(mo, yr)) return ST_DAY;
      if (hr > 23) return ST_HOUR;
      if (mi > 59) return ST_MINUTE;
      if (se > 60) return ST_SECOND;
      return ST_OK;
    endfunction

    function bit is_dig(logic [7:0] c);
      return c >= ChZero && c <= ChNine;
    endfunction

    function void zone(logic [7:0] c);
      if (!acc_off) begin
        if (c == ChZ) ph = PH_DONE; else fail(ST_ZONE);
      end else if (c == ChPlus || c == ChDash) begin
        oneg = (c == ChDash);
        ph = PH_OH1;
      end else if (c == ChZ || c == ChZLow) begin
        ph = PH_DONE;
      end else begin
        fail(ST_ZONE);
      end
    endfunction

    function void frac_digit(logic [7:0] c);
      if (fcnt < FracDigitsDef && fcnt < 15) begin
        frac = frac * 10 + (c - ChZero);
        fcnt++;
      end
    endfunction

    function void take(logic [7:0] c);
      int p, d;
      p = pos;
      d = c - ChZero;
      case (ph)
        PH_PREFIX: begin
          if (p == 4 || p == 7) begin
            if (c != ChDash) fail(ST_FORMAT);
          end else if (p == 13 || p == 16) begin
            if (c != ChColon) fail(ST_FORMAT);
          end else if (p == 10) sep = (c == ChT || c == ChTLow);
          else if (!is_dig(c)) fail(ST_FORMAT);
          else if (p < 4) yr = yr * 10 + d;
          else if (p < 7) mo = mo * 10 + d;
          else if (p < 10) dy = dy * 10 + d;
          else if (p < 13) hr = hr * 10 + d;
          else if (p < 16) mi = mi * 10 + d;
          else se = se * 10 + d;
          if (pos < 63) pos++;
          if (ferr == ST_OK && p == 18) begin
            fail(prefix_status());
            ph = PH_ZONE;
          end
        end
        PH_ZONE: if (c == ChDot) ph = PH_FRAC0; else zone(c);
        PH_FRAC0: begin
          if (is_dig(c)) begin frac_digit(c); ph = PH_FRAC; end
          else fail(ST_NOFRAC);
        end
        PH_FRAC: if (is_dig(c)) frac_digit(c); else zone(c);
        PH_OH1, PH_OH2: begin
          if (!is_dig(c)) fail(ST_OFFFMT);
          else begin
            oh = oh * 10 + d;
            ph = (ph == PH_OH1) ? PH_OH2 : PH_OCOL;
          end
        end
        PH_OCOL: if (c == ChColon) ph = PH_OM1; else fail(ST_OFFFMT);
        PH_OM1, PH_OM2: begin
          if (!is_dig(c)) fail(ST_OFFFMT);
          else begin
            om = om * 10 + d;
            if (ph == PH_OM1) ph = PH_OM2;
            else if (oh > 23) fail(ST_OFFHOUR);
            else if (om > 59) fail(ST_OFFMIN);
            else ph = PH_DONE;
          end
        end
        default: fail(ST_EXTRA);
      endcase
    endfunction

    function longint epoch();
      longint ey, era, yoe, doy, doe, dd, off, t;
      ey  = (mo <= 2) ? yr - 1 : yr;
      era = (ey >= 0 ? ey : ey - 399) / 400;
      yoe = ey - era * 400;
      doy = (153 * (mo > 2 ? mo - 3 : mo + 9) + 2) / 5 + dy - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      dd  = era * 146097 + doe - 719468;
      off = (longint'(oh) * 60 + om) * 60;
      t   = ((dd * 24 + hr) * 60 + mi) * 60 + se;
      return oneg ? t + off : t - off;
    endfunction

    function void note(logic [7:0] c, bit last);
      stamp_t e;
      longint scale;
      if (ferr == ST_OK) take(c);
      if (!last) return;
      e.status = ferr;
      if (e.status == ST_OK) begin
        case (ph)
          PH_PREFIX: e.status = ST_FORMAT;
          PH_ZONE:   e.status = ST_SHORT;
          PH_FRAC0:  e.status = ST_NOFRAC;
          PH_FRAC:   e.status = ST_ZONE;
          PH_DONE:   e.status = ST_OK;
          default:   e.status = ST_OFFFMT;
        endcase
      end
      e.secs = 0;
      e.fs = 0;
      if (e.status == ST_OK) begin
        scale = 1;
        repeat (15 - fcnt) scale *= 10;
        e.secs = 39'(epoch());
        e.fs = 50'(frac * scale);
      end
      pending.push_back(e);
      clear();
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void check(logic [3:0] st, logic signed [38:0] secs, logic [49:0] fs);
      stamp_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result status=%0d", st));
        return;
      end
      e = pending.pop_front();
      results++;
      if (e.status == ST_OK) ok_results++;
      if (st !== e.status || secs !== e.secs || fs !== e.fs)
        report($sformatf("got st=%0d s=%0d fs=%0d, want st=%0d s=%0d fs=%0d",
                         st, secs, fs, e.status, e.secs, e.fs));
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we = 0;
  logic cfg_wdata = 0;

  rfc_in_if  in_ch();
  rfc_out_if out_ch();

  rfc3339_timestamp_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  stamp_scoreboard sb = new();
  bit  calm = 0;
  int  hold_cycles = 0;
  int  bytes_sent = 0, strings_sent = 0, cfg_writes = 0;
  int  idle_count = 0;

  always #1 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 0;
    in_ch.text_byte = 0;
    in_ch.is_last = 0;
    out_ch.ready = 0;
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ch.ready = 0;
      hold_cycles--;
    end else if (calm) out_ch.ready = 1;
    else out_ch.ready = ($urandom_range(99) >= 30);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check(out_ch.status, out_ch.epoch_seconds, out_ch.femtoseconds);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
      idle_count = 0;
    else idle_count++;
    if (idle_count >= WatchLimit) begin
      $display("Watchdog: no transaction for %0d cycles", WatchLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] c, bit last);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 30) begin
      in_ch.valid = 0;
      @(negedge clk_i);
    end
    in_ch.valid = 1;
    in_ch.text_byte = c;
    in_ch.is_last = last;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note(c, last);
    bytes_sent++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    strings_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid = 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_offset_mode(bit v);
    drain();
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we = 0;
    sb.acc_off = v;
    cfg_writes++;
  endtask

  function automatic string random_stamp();
    string s;
    int y, m, d, n;
    y = ($urandom_range(3) == 0) ? $urandom_range(9999) : $urandom_range(1900, 2100);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, sb.days_in(m, y));
    s = $sformatf("%04d-%02d-%02d%s%02d:%02d:%02d", y, m, d,
                  $urandom_range(1) ? "T" : "t", $urandom_range(23),
                  $urandom_range(59), $urandom_range(60));
    if ($urandom_range(1)) begin
      n = ($urandom_range(4) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 15);
      s = {s, "."};
      repeat (n) s = {s, $sformatf("%0d", $urandom_range(9))};
    end
    case ($urandom_range(3))
      0: s = {s, "Z"};
      1: s = {s, "z"};
      default: s = {s, $urandom_range(1) ? "+" : "-",
                    $sformatf("%02d:%02d",
                      $urandom_range(7) == 0 ? $urandom_range(99) : $urandom_range(23),
                      $urandom_range(7) == 0 ? $urandom_range(99) : $urandom_range(59))};
    endcase
    return s;
  endfunction

  function automatic string mangle(string s);
    string r;
    int k;
    r = s;
    case ($urandom_range(3))
      0: begin
        k = $urandom_range(s.len() - 1);
        r[k] = 8'($urandom_range(1, 255));
      end
      1: r = s.substr(0, $urandom_range(s.len() - 2));
      2: r = {s, string'(8'($urandom_range(1, 255)))};
      default: begin
        r = "";
        repeat ($urandom_range(1, 30)) r = {r, string'(8'($urandom_range(1, 255)))};
      end
    endcase
    return r;
  endfunction

  string directed[$] = '{
    "1970-01-01T00:00:00Z", "0000-01-01T00:00:00Z",
    "9999-12-31T23:59:60.999999999999999-23:59", "2000-02-29t12:00:00z",
    "1900-02-29T00:00:00Z", "2024-13-01T00:00:00Z", "2024-00-10T00:00:00Z",
    "2024-04-31T00:00:00Z", "2024-01-01T24:00:00Z", "2024-01-01T23:60:00Z",
    "2024-01-01T23:59:61Z", "2024-01-01X00:00:00Z", "2024/01-01T00:00:00Z",
    "2024-01-01T00:00:00", "2024-01-01T00:00:00.", "2024-01-01T00:00:00.5",
    "2024-01-01T00:00:00.1234567890123456789Z", "2024-01-01T00:00:00+24:00",
    "2024-01-01T00:00:00+05:60", "2024-01-01T00:00:00+05-00",
    "2024-01-01T00:00:00+05", "2024-01-01T00:00:00Z1", "2024-01-0", "1a24-01-01T00:00:00Q"
  };

  initial begin
    string s;
    int next_cfg;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    foreach (directed[i]) send_str(directed[i]);
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    set_offset_mode(0);
    send_str("2024-06-15T10:20:30Z");
    send_str("2024-06-15T10:20:30z");
    send_str("2024-06-15T10:20:30.25+01:00");
    set_offset_mode(1);

    hold_cycles = 200;
    repeat (4) send_str(random_stamp());
    drain();

    next_cfg = bytes_sent + 300;
    while (bytes_sent < 1650) begin
      calm = (bytes_sent > 700 && bytes_sent < 950);
      s = random_stamp();
      if ($urandom_range(99) < 30) s = mangle(s);
      send_str(s);
      if (bytes_sent >= next_cfg) begin
        set_offset_mode($urandom_range(1));
        next_cfg = bytes_sent + 300;
      end
    end
    calm = 0;
    set_offset_mode(1);

    $display("Sent %0d strings (%0d bytes), %0d results checked, %0d valid stamps,",
             strings_sent, bytes_sent, sb.results, sb.ok_results);
    $display("with %0d offset-mode writes and a long output hold-off", cfg_writes);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
